// ===== hw/rtl/vaxr_pkg.sv =====
// Shared types, constants and the arctangent table of the axis rotator.
`timescale 1ns / 1ps

package vaxr_pkg;

	// Default sizes
	localparam int COORD_BITS_DEF      = 32;
	localparam int ROTATION_STAGES_DEF = 16;

	// CORDIC datapath widths: x/y in Q2.30 with headroom, z in 2^-32 turn units
	localparam int CW = 34;
	localparam int ZW = 34;

	// Gain-compensated start value, 0.6072529... in Q2.30
	localparam logic signed [CW-1:0] GAIN_Q30 = 34'h026DD3B6A;

	// Operation codes
	typedef enum logic [1:0] {
		OP_ROT_X = 2'd0,
		OP_ROT_Y = 2'd1,
		OP_ROT_Z = 2'd2,
		OP_PASS  = 2'd3
	} op_t;

	// State handed from one CORDIC cell to the next
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic [1:0]           quad;
		op_t                  op;
	} cordic_t;

	// Fraction bits of sine/cosine ahead of the multipliers
	function automatic int trig_frac(input int coord_bits);
		return ((61 - coord_bits) < 30) ? (61 - coord_bits) : 30;
	endfunction

	// atan(2^-i) in units of 2^-32 turn, rounded
	function automatic logic signed [ZW-1:0] atan_val(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0:  r = ZW'(536870912);
			1:  r = ZW'(316933406);
			2:  r = ZW'(167458907);
			3:  r = ZW'(85004756);
			4:  r = ZW'(42667331);
			5:  r = ZW'(21354465);
			6:  r = ZW'(10679838);
			7:  r = ZW'(5340245);
			8:  r = ZW'(2670163);
			9:  r = ZW'(1335087);
			10: r = ZW'(667544);
			11: r = ZW'(333772);
			12: r = ZW'(166886);
			13: r = ZW'(83443);
			14: r = ZW'(41722);
			15: r = ZW'(20861);
			16: r = ZW'(10430);
			17: r = ZW'(5215);
			18: r = ZW'(2608);
			19: r = ZW'(1304);
			20: r = ZW'(652);
			21: r = ZW'(326);
			22: r = ZW'(163);
			23: r = ZW'(81);
			24: r = ZW'(41);
			25: r = ZW'(20);
			26: r = ZW'(10);
			27: r = ZW'(5);
			28: r = ZW'(3);
			29: r = ZW'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/vaxr_cell.sv =====
// One CORDIC rotation cell: a single micro-rotation plus its pipeline register.
`timescale 1ns / 1ps

module vaxr_cell #(
	parameter int COORD_BITS = vaxr_pkg::COORD_BITS_DEF,
	parameter int STAGE      = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  vaxr_pkg::cordic_t             in_st,
	input  logic [2:0][COORD_BITS-1:0]    in_pt,
	output logic                          out_valid,
	input  logic                          out_ready,
	output vaxr_pkg::cordic_t             out_st,
	output logic [2:0][COORD_BITS-1:0]    out_pt
);
	import vaxr_pkg::*;

	logic signed [CW-1:0] x_in, y_in, dx, dy;
	logic signed [ZW-1:0] z_in, at;
	cordic_t              nxt;
	logic                 valid_q;
	cordic_t              st_q;
	logic [2:0][COORD_BITS-1:0] pt_q;

	// Micro-rotation by +/- atan(2^-STAGE), direction from the sign of z
	always_comb begin
		x_in = in_st.x;
		y_in = in_st.y;
		z_in = in_st.z;
		dx   = y_in >>> STAGE;
		dy   = x_in >>> STAGE;
		at   = atan_val(STAGE);
		nxt  = in_st;
		if (!z_in[ZW-1]) begin
			nxt.x = x_in - dx;
			nxt.y = y_in + dy;
			nxt.z = z_in - at;
		end else begin
			nxt.x = x_in + dx;
			nxt.y = y_in - dy;
			nxt.z = z_in + at;
		end
	end

	assign in_ready = !valid_q || out_ready;

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			st_q <= nxt;
			pt_q <= in_pt;
		end
	end

	assign out_valid = valid_q;
	assign out_st    = st_q;
	assign out_pt    = pt_q;

endmodule

// ===== hw/rtl/vaxr_mix.sv =====
// Quadrant fold, coordinate multiply, rounding and saturation behind the CORDIC chain.
`timescale 1ns / 1ps

module vaxr_mix #(
	parameter int COORD_BITS = vaxr_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  vaxr_pkg::cordic_t             in_st,
	input  logic [2:0][COORD_BITS-1:0]    in_pt,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [COORD_BITS-1:0]         out_x,
	output logic [COORD_BITS-1:0]         out_y,
	output logic [COORD_BITS-1:0]         out_z,
	output logic                          out_clip
);
	import vaxr_pkg::*;

	localparam int N   = COORD_BITS;
	localparam int TF  = trig_frac(COORD_BITS);
	localparam int SH  = 30 - TF;
	localparam int CSW = TF + 2;
	localparam int PW  = N + CSW;
	localparam int SW  = PW + 1;
	localparam logic signed [SW-1:0] RND  = SW'(1) <<< (TF - 1);
	localparam logic signed [SW-1:0] MAXV = {{(SW-N+1){1'b0}}, {(N-1){1'b1}}};
	localparam logic signed [SW-1:0] MINV = {{(SW-N+1){1'b1}}, {(N-1){1'b0}}};

	// Handshake chain
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Stage 1: quadrant fold, trim to TF fraction bits, pick operand pair
	logic signed [CW-1:0]  cx, cy, c_full, s_full, c_sh, s_sh;
	logic signed [N-1:0]   a_nx, b_nx;
	logic signed [CSW-1:0] c_s1, s_s1;
	logic signed [N-1:0]   a_s1, b_s1;
	logic [2:0][N-1:0]     pt_s1, pt_s2, pt_s3;
	op_t                   op_s1, op_s2, op_s3;

	always_comb begin
		cx = in_st.x;
		cy = in_st.y;
		case (in_st.quad)
			2'd0: begin
				c_full = cx;
				s_full = cy;
			end
			2'd1: begin
				c_full = -cy;
				s_full = cx;
			end
			2'd2: begin
				c_full = -cx;
				s_full = -cy;
			end
			default: begin
				c_full = cy;
				s_full = -cx;
			end
		endcase
		c_sh = c_full >>> SH;
		s_sh = s_full >>> SH;
		case (in_st.op)
			OP_ROT_X: begin
				a_nx = $signed(in_pt[1]);
				b_nx = $signed(in_pt[2]);
			end
			OP_ROT_Y: begin
				a_nx = $signed(in_pt[2]);
				b_nx = $signed(in_pt[0]);
			end
			default: begin
				a_nx = $signed(in_pt[0]);
				b_nx = $signed(in_pt[1]);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			c_s1  <= c_sh[CSW-1:0];
			s_s1  <= s_sh[CSW-1:0];
			a_s1  <= a_nx;
			b_s1  <= b_nx;
			pt_s1 <= in_pt;
			op_s1 <= in_st.op;
		end
	end

	// Stage 2: the four products
	logic signed [PW-1:0] ca_s2, sb_s2, sa_s2, cb_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			ca_s2 <= PW'(c_s1) * PW'(a_s1);
			sb_s2 <= PW'(s_s1) * PW'(b_s1);
			sa_s2 <= PW'(s_s1) * PW'(a_s1);
			cb_s2 <= PW'(c_s1) * PW'(b_s1);
			pt_s2 <= pt_s1;
			op_s2 <= op_s1;
		end
	end

	// Stage 3: combine products with rounding offset
	logic signed [SW-1:0] na_s3, nb_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			na_s3 <= SW'(ca_s2) - SW'(sb_s2) + RND;
			nb_s3 <= SW'(sa_s2) + SW'(cb_s2) + RND;
			pt_s3 <= pt_s2;
			op_s3 <= op_s2;
		end
	end

	// Stage 4: scale down, saturate, place results by axis
	function automatic logic [N:0] sat_round(input logic signed [SW-1:0] acc);
		logic signed [SW-1:0] v;
		v = acc >>> TF;
		if (v > MAXV) return {1'b1, MAXV[N-1:0]};
		if (v < MINV) return {1'b1, MINV[N-1:0]};
		return {1'b0, v[N-1:0]};
	endfunction

	logic [N:0]   na_sat, nb_sat;
	logic [N-1:0] x_nx, y_nx, z_nx;
	logic         clip_nx;
	logic [N-1:0] x_s4, y_s4, z_s4;
	logic         clip_s4;

	always_comb begin
		na_sat  = sat_round(na_s3);
		nb_sat  = sat_round(nb_s3);
		x_nx    = pt_s3[0];
		y_nx    = pt_s3[1];
		z_nx    = pt_s3[2];
		clip_nx = na_sat[N] | nb_sat[N];
		case (op_s3)
			OP_ROT_X: begin
				y_nx = na_sat[N-1:0];
				z_nx = nb_sat[N-1:0];
			end
			OP_ROT_Y: begin
				z_nx = na_sat[N-1:0];
				x_nx = nb_sat[N-1:0];
			end
			OP_ROT_Z: begin
				x_nx = na_sat[N-1:0];
				y_nx = nb_sat[N-1:0];
			end
			default: begin
				clip_nx = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			x_s4    <= x_nx;
			y_s4    <= y_nx;
			z_s4    <= z_nx;
			clip_s4 <= clip_nx;
		end
	end

	assign out_valid = v_s4;
	assign out_x     = x_s4;
	assign out_y     = y_s4;
	assign out_z     = z_s4;
	assign out_clip  = clip_s4;

endmodule

// ===== hw/rtl/vector_axis_rotator_top.sv =====
// The path holds ROTATION_STAGES + 4 register stages from request to result.
// Throughput: one request per cycle while res_ready is high; each CORDIC cell and each
// of the four back-end stages (fold, multiply, sum, saturate) holds one request.
// Stalls collapse bubbles: a stage takes new data whenever it is empty.
// Reset (arst_n low) clears only the stage valid flags; data is not reset.
`timescale 1ns / 1ps

module vector_axis_rotator_top #(
	parameter int COORD_BITS      = vaxr_pkg::COORD_BITS_DEF,
	parameter int ROTATION_STAGES = vaxr_pkg::ROTATION_STAGES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  logic [1:0]             operation,
	input  logic [COORD_BITS-1:0]  coord_x,
	input  logic [COORD_BITS-1:0]  coord_y,
	input  logic [COORD_BITS-1:0]  coord_z,
	input  logic [15:0]            angle,
	output logic                   res_valid,
	input  logic                   res_ready,
	output logic [COORD_BITS-1:0]  rot_x,
	output logic [COORD_BITS-1:0]  rot_y,
	output logic [COORD_BITS-1:0]  rot_z,
	output logic                   clipped
);
	import vaxr_pkg::*;

	localparam int S = ROTATION_STAGES;

	cordic_t                    st_in;
	cordic_t                    st_w [0:S];
	logic [2:0][COORD_BITS-1:0] pt_w [0:S];
	logic                       v_w  [0:S];
	logic                       r_w  [0:S];

	// Chain entry: gain-compensated start vector and quadrant residual
	always_comb begin
		st_in.x    = GAIN_Q30;
		st_in.y    = '0;
		st_in.z    = {{(ZW-30){1'b0}}, angle[13:0], 16'h0000};
		st_in.quad = angle[15:14];
		st_in.op   = op_t'(operation);
	end

	assign st_w[0]   = st_in;
	assign pt_w[0]   = {coord_z, coord_y, coord_x};
	assign v_w[0]    = req_valid;
	assign req_ready = r_w[0];

	// CORDIC cell chain
	for (genvar i = 0; i < S; i++) begin : g_cell
		vaxr_cell #(
			.COORD_BITS (COORD_BITS),
			.STAGE      (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_w[i]),
			.in_ready  (r_w[i]),
			.in_st     (st_w[i]),
			.in_pt     (pt_w[i]),
			.out_valid (v_w[i+1]),
			.out_ready (r_w[i+1]),
			.out_st    (st_w[i+1]),
			.out_pt    (pt_w[i+1])
		);
	end

	// Back end: fold, multiply, round, saturate
	vaxr_mix #(
		.COORD_BITS (COORD_BITS)
	) u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_w[S]),
		.in_ready  (r_w[S]),
		.in_st     (st_w[S]),
		.in_pt     (pt_w[S]),
		.out_valid (res_valid),
		.out_ready (res_ready),
		.out_x     (rot_x),
		.out_y     (rot_y),
		.out_z     (rot_z),
		.out_clip  (clipped)
	);

endmodule

// ===== sim/tb_vector_axis_rotator_top.sv =====
// Self-checking testbench for vector_axis_rotator_top: directed and random rotations.
`timescale 1ns / 1ps

module tb_vector_axis_rotator_top;

	import vaxr_pkg::*;

	localparam int COORD_BITS      = 32;
	localparam int ROTATION_STAGES = 16;
	localparam int TRIG_FRAC       = ((61 - COORD_BITS) < 30) ? (61 - COORD_BITS) : 30;
	localparam int LATENCY         = ROTATION_STAGES + 4;
	localparam int RANDOM_REQUESTS = 500;

	localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(32'h0001_0000);
	localparam logic [COORD_BITS-1:0] COORD_NEG = '1;

	// One rotation request and one rotated point
	typedef struct {
		op_t                   op;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] z;
		logic [15:0]           ang;
	} rot_req_t;

	typedef struct {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] z;
		logic                  clip;
	} rot_point_t;

	// Predicts each rotated point and checks results in request order
	class rotation_scoreboard;
		rot_point_t expected_points[$];
		int         mismatches      = 0;
		int         results_checked = 0;
		int         clipped_results = 0;
		// atan(2^-i) in 2^-32 turn units
		longint     atan_turn [30] = '{
			536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
			41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
			10, 5, 3, 1};

		// CORDIC sine/cosine in TRIG_FRAC fraction bits
		function void trig_pair(input logic [15:0] ang, output longint cs, output longint sn);
			longint cx, cy, cz, dx, dy, c, s;
			cx = 64'sh26DD3B6A;
			cy = 0;
			cz = longint'({ang[13:0], 16'h0000});
			for (int i = 0; i < ROTATION_STAGES && i < 30; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cz >= 0) begin
					cx = cx - dx;
					cy = cy + dy;
					cz = cz - atan_turn[i];
				end else begin
					cx = cx + dx;
					cy = cy - dy;
					cz = cz + atan_turn[i];
				end
			end
			// fold back into the full turn
			case (ang[15:14])
				2'd0: begin c = cx;  s = cy;  end
				2'd1: begin c = -cy; s = cx;  end
				2'd2: begin c = -cx; s = -cy; end
				default: begin c = cy; s = -cx; end
			endcase
			cs = c >>> (30 - TRIG_FRAC);
			sn = s >>> (30 - TRIG_FRAC);
		endfunction

		// round half up, then clamp to the coordinate range
		function longint round_sat(input longint acc, inout logic clip);
			longint v, hi, lo;
			hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
			lo = -(64'sd1 <<< (COORD_BITS - 1));
			v  = (acc + (64'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
			if (v > hi) begin
				clip = 1'b1;
				v = hi;
			end else if (v < lo) begin
				clip = 1'b1;
				v = lo;
			end
			return v;
		endfunction

		function rot_point_t predict_rotation(input rot_req_t r);
			longint     px, py, pz, cs, sn, a, b;
			logic       clip;
			rot_point_t p;
			px   = longint'($signed(r.x));
			py   = longint'($signed(r.y));
			pz   = longint'($signed(r.z));
			clip = 1'b0;
			if (r.op != OP_PASS) begin
				trig_pair(r.ang, cs, sn);
				case (r.op)
					OP_ROT_X: begin
						a  = round_sat(cs * py - sn * pz, clip);
						b  = round_sat(sn * py + cs * pz, clip);
						py = a;
						pz = b;
					end
					OP_ROT_Y: begin
						a  = round_sat(cs * pz - sn * px, clip);
						b  = round_sat(sn * pz + cs * px, clip);
						pz = a;
						px = b;
					end
					default: begin
						a  = round_sat(cs * px - sn * py, clip);
						b  = round_sat(sn * px + cs * py, clip);
						px = a;
						py = b;
					end
				endcase
			end
			p.x    = px[COORD_BITS-1:0];
			p.y    = py[COORD_BITS-1:0];
			p.z    = pz[COORD_BITS-1:0];
			p.clip = clip;
			return p;
		endfunction

		function void note_request(input rot_req_t r);
			expected_points = {expected_points, predict_rotation(r)};
		endfunction

		function void check_result(input logic [COORD_BITS-1:0] rx, input logic [COORD_BITS-1:0] ry,
				input logic [COORD_BITS-1:0] rz, input logic clip);
			rot_point_t e;
			if (expected_points.size() == 0) begin
				$error("result with no request outstanding: x=%h y=%h z=%h clipped=%b",
					rx, ry, rz, clip);
				mismatches++;
				return;
			end
			e = expected_points.pop_front();
			results_checked++;
			if (clip)
				clipped_results++;
			if (rx !== e.x) begin
				$error("rot_x: expected %h, actual %h", e.x, rx);
				mismatches++;
			end
			if (ry !== e.y) begin
				$error("rot_y: expected %h, actual %h", e.y, ry);
				mismatches++;
			end
			if (rz !== e.z) begin
				$error("rot_z: expected %h, actual %h", e.z, rz);
				mismatches++;
			end
			if (clip !== e.clip) begin
				$error("clipped: expected %b, actual %b", e.clip, clip);
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_ready;
	logic [1:0]            operation;
	logic [COORD_BITS-1:0] coord_x;
	logic [COORD_BITS-1:0] coord_y;
	logic [COORD_BITS-1:0] coord_z;
	logic [15:0]           angle;
	logic                  res_valid;
	logic                  res_ready;
	logic [COORD_BITS-1:0] rot_x;
	logic [COORD_BITS-1:0] rot_y;
	logic [COORD_BITS-1:0] rot_z;
	logic                  clipped;

	rotation_scoreboard board;
	bit                 no_idle;
	int                 op_count [4];

	vector_axis_rotator_top #(
		.COORD_BITS     (COORD_BITS),
		.ROTATION_STAGES(ROTATION_STAGES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.operation(operation),
		.coord_x  (coord_x),
		.coord_y  (coord_y),
		.coord_z  (coord_z),
		.angle    (angle),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.rot_x    (rot_x),
		.rot_y    (rot_y),
		.rot_z    (rot_z),
		.clipped  (clipped)
	);

	// 100 MHz clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("Timeout: results still outstanding");
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic rot_req_t make_req(input op_t op, input logic [COORD_BITS-1:0] x,
			input logic [COORD_BITS-1:0] y, input logic [COORD_BITS-1:0] z, input logic [15:0] ang);
		rot_req_t r;
		r.op  = op;
		r.x   = x;
		r.y   = y;
		r.z   = z;
		r.ang = ang;
		return r;
	endfunction

	// Coordinates: extremes, small values around zero, or any pattern
	function automatic logic [COORD_BITS-1:0] pick_coord();
		logic [COORD_BITS-1:0] v;
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 4))
					0: v = COORD_MAX;
					1: v = COORD_MIN;
					2: v = '0;
					3: v = COORD_NEG;
					default: v = COORD_ONE;
				endcase
			end
			1, 2, 3: v = COORD_BITS'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
			default: v = COORD_BITS'({$urandom, $urandom});
		endcase
		return v;
	endfunction

	// Angles: any value, or near a quadrant boundary
	function automatic logic [15:0] pick_angle();
		logic [15:0] a;
		if ($urandom_range(0, 3) == 0)
			a = {2'($urandom_range(0, 3)), 14'h0} + 16'($urandom_range(0, 4)) - 16'd2;
		else
			a = 16'($urandom);
		return a;
	endfunction

	// Present one request and hold it until accepted
	task automatic send_request(input rot_req_t r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		operation <= r.op;
		coord_x   <= r.x;
		coord_y   <= r.y;
		coord_z   <= r.z;
		angle     <= r.ang;
		do @(posedge clk); while (!req_ready);
		board.note_request(r);
		op_count[r.op]++;
	endtask

	// Accept results with random back-pressure
	task automatic drain_results();
		int stall;
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
			board.check_result(rot_x, rot_y, rot_z, clipped);
		end
	endtask

	// Stimulus and end of run
	initial begin
		board     = new();
		no_idle   = 1'b0;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		res_ready <= 1'b0;
		operation <= OP_PASS;
		coord_x   <= '0;
		coord_y   <= '0;
		coord_z   <= '0;
		angle     <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			drain_results();
		join_none

		// directed: pass through, each axis, quadrant edges, saturation
		send_request(make_req(OP_PASS, COORD_MAX, COORD_MIN, '0, 16'h1234));
		send_request(make_req(OP_PASS, COORD_NEG, COORD_ONE, COORD_MIN, 16'hFFFF));
		send_request(make_req(OP_PASS, '0, '0, '0, 16'h0000));
		send_request(make_req(OP_ROT_X, COORD_ONE, COORD_ONE << 1, COORD_ONE * 3, 16'h0000));
		send_request(make_req(OP_ROT_Y, COORD_ONE, COORD_ONE << 1, COORD_ONE * 3, 16'h4000));
		send_request(make_req(OP_ROT_Z, COORD_ONE, COORD_ONE << 1, COORD_ONE * 3, 16'h8000));
		send_request(make_req(OP_ROT_X, COORD_ONE, COORD_ONE << 1, COORD_ONE * 3, 16'hC000));
		send_request(make_req(OP_ROT_Y, COORD_ONE, COORD_NEG, COORD_ONE, 16'hFFFF));
		send_request(make_req(OP_ROT_Z, COORD_ONE, COORD_NEG, COORD_ONE, 16'h3FFF));
		send_request(make_req(OP_ROT_X, '0, COORD_MAX, COORD_MIN, 16'h2000));
		send_request(make_req(OP_ROT_Y, COORD_MIN, '0, COORD_MIN, 16'h6000));
		send_request(make_req(OP_ROT_Z, COORD_MAX, COORD_MAX, '0, 16'h2000));
		send_request(make_req(OP_ROT_Z, COORD_MIN, COORD_MIN, COORD_MIN, 16'h8000));
		send_request(make_req(OP_ROT_X, COORD_MIN, COORD_MIN, COORD_MAX, 16'hE000));
		send_request(make_req(OP_ROT_X, '0, '0, '0, 16'hA5A5));
		send_request(make_req(OP_ROT_Y, COORD_NEG, COORD_NEG, COORD_NEG, 16'h5A5A));
		send_request(make_req(OP_ROT_Z, COORD_BITS'(1), COORD_BITS'(1), '0, 16'h0001));
		send_request(make_req(OP_ROT_X, COORD_MAX, COORD_MAX, COORD_MAX, 16'h4000));
		send_request(make_req(OP_ROT_Y, COORD_MIN, COORD_MAX, COORD_MIN, 16'h7FFF));
		send_request(make_req(OP_ROT_Z, COORD_MAX, COORD_MIN, COORD_MAX, 16'hC000));
		send_request(make_req(OP_ROT_Y, COORD_MAX, COORD_ONE, COORD_MAX, 16'hA000));

		// random: choose anew between idling and full-rate bursts every 50 requests
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 50 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			send_request(make_req(op_t'($urandom_range(0, 3)), pick_coord(), pick_coord(),
				pick_coord(), pick_angle()));
		end
		no_idle = 1'b0;
		req_valid <= 1'b0;

		// drain, then watch for stray results
		while (board.expected_points.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("Covered %0d rotations about X, %0d about Y, %0d about Z, %0d pass-through",
			op_count[OP_ROT_X], op_count[OP_ROT_Y], op_count[OP_ROT_Z], op_count[OP_PASS]);
		$display("%0d results checked, %0d saturated, %0d mismatches",
			board.results_checked, board.clipped_results, board.mismatches);
		if (board.mismatches == 0 && board.expected_points.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/vaxr_pkg.sv
hw/rtl/vaxr_cell.sv
hw/rtl/vaxr_mix.sv
hw/rtl/vector_axis_rotator_top.sv
sim/tb_vector_axis_rotator_top.sv
